// ===== rtl/upsc_pkg.sv =====
// shared types and constants for the integer nearest-neighbor upscaler
`timescale 1ns / 1ps

package upsc_pkg;

    localparam int SRC_W_BITS    = 11;
    localparam int SRC_H_BITS    = 10;
    localparam int SCALE_BITS    = 4;
    localparam int PIX_BITS      = 16;
    localparam int ADDR_BITS     = 20;
    localparam int CFG_DATA_BITS = 11;
    localparam int CFG_IDX_BITS  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ASPECT_KEEP = 2'd2;

    // register reset values
    localparam logic [SRC_W_BITS-1:0] SRC_WIDTH_RST  = 11'd320;
    localparam logic [SRC_H_BITS-1:0] SRC_HEIGHT_RST = 10'd240;

    typedef struct packed {
        logic [SCALE_BITS-1:0] sx;
        logic [SCALE_BITS-1:0] sy;
    } scale_t;

endpackage

// ===== rtl/upsc_geom.sv =====
// configuration registers and two-step geometry derivation
`timescale 1ns / 1ps

module upsc_geom #(
    parameter int FRAME_WIDTH  = 1280,
    parameter int FRAME_HEIGHT = 720,
    parameter int MAX_SCALE    = 8,
    parameter int COL_W        = 11,
    parameter int ROW_W        = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [upsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [upsc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output logic                                restart,
    output logic                                busy,
    output upsc_pkg::scale_t                    scale,
    output logic [COL_W-1:0]                    offset_x,
    output logic [ROW_W-1:0]                    offset_y,
    output logic [upsc_pkg::SRC_W_BITS-1:0]     eff_w,
    output logic [upsc_pkg::SRC_H_BITS-1:0]     eff_h
);

    localparam int CMP_W  = 13;
    localparam int PROD_W = upsc_pkg::SRC_W_BITS + upsc_pkg::SCALE_BITS;

    typedef enum logic [1:0] {GEO_IDLE, GEO_FACTOR, GEO_OFFSET} geo_state_t;

    geo_state_t                           state_reg;
    logic [upsc_pkg::SRC_W_BITS-1:0]      src_width_reg;
    logic [upsc_pkg::SRC_H_BITS-1:0]      src_height_reg;
    logic                                 aspect_reg;
    upsc_pkg::scale_t                     scale_reg;
    logic [COL_W-1:0]                     offset_x_reg;
    logic [ROW_W-1:0]                     offset_y_reg;

    logic                                 hit;
    logic [upsc_pkg::SCALE_BITS-1:0]      fx_calc;
    logic [upsc_pkg::SCALE_BITS-1:0]      fy_calc;
    upsc_pkg::scale_t                     scale_next;
    logic [PROD_W-1:0]                    dw;
    logic [PROD_W-1:0]                    dh;
    logic [COL_W-1:0]                     offset_x_next;
    logic [ROW_W-1:0]                     offset_y_next;

    // writes beyond the register list do nothing
    always_comb
    begin
        case (cfg_index)
            upsc_pkg::REG_SRC_WIDTH:   hit = cfg_we;
            upsc_pkg::REG_SRC_HEIGHT:  hit = cfg_we;
            upsc_pkg::REG_ASPECT_KEEP: hit = cfg_we;
            default:                   hit = 1'b0;
        endcase
    end

    // clamp dimensions to 1..frame
    always_comb
    begin
        if (src_width_reg == '0)
            eff_w = upsc_pkg::SRC_W_BITS'(1);
        else if (CMP_W'(src_width_reg) > CMP_W'(FRAME_WIDTH))
            eff_w = upsc_pkg::SRC_W_BITS'(FRAME_WIDTH);
        else
            eff_w = src_width_reg;
        if (src_height_reg == '0)
            eff_h = upsc_pkg::SRC_H_BITS'(1);
        else if (CMP_W'(src_height_reg) > CMP_W'(FRAME_HEIGHT))
            eff_h = upsc_pkg::SRC_H_BITS'(FRAME_HEIGHT);
        else
            eff_h = src_height_reg;
    end

    // largest factor up to max scale that still fits the frame
    always_comb
    begin
        fx_calc = upsc_pkg::SCALE_BITS'(1);
        fy_calc = upsc_pkg::SCALE_BITS'(1);
        for (int k = 1; k <= MAX_SCALE; k++)
        begin
            if (PROD_W'(eff_w) * PROD_W'(k) <= PROD_W'(FRAME_WIDTH))
                fx_calc = upsc_pkg::SCALE_BITS'(k);
            if (PROD_W'(eff_h) * PROD_W'(k) <= PROD_W'(FRAME_HEIGHT))
                fy_calc = upsc_pkg::SCALE_BITS'(k);
        end
        if (aspect_reg)
        begin
            scale_next.sx = (fx_calc < fy_calc) ? fx_calc : fy_calc;
            scale_next.sy = scale_next.sx;
        end
        else
        begin
            scale_next.sx = fx_calc;
            scale_next.sy = fy_calc;
        end
    end

    // centering offsets from the registered factors
    always_comb
    begin
        dw = PROD_W'(eff_w) * PROD_W'(scale_reg.sx);
        dh = PROD_W'(eff_h) * PROD_W'(scale_reg.sy);
        if (dw < PROD_W'(FRAME_WIDTH))
            offset_x_next = COL_W'((PROD_W'(FRAME_WIDTH) - dw) >> 1);
        else
            offset_x_next = '0;
        if (dh < PROD_W'(FRAME_HEIGHT))
            offset_y_next = ROW_W'((PROD_W'(FRAME_HEIGHT) - dh) >> 1);
        else
            offset_y_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= GEO_IDLE;
            src_width_reg  <= upsc_pkg::SRC_WIDTH_RST;
            src_height_reg <= upsc_pkg::SRC_HEIGHT_RST;
            aspect_reg     <= 1'b0;
            scale_reg.sx   <= upsc_pkg::SCALE_BITS'(1);
            scale_reg.sy   <= upsc_pkg::SCALE_BITS'(1);
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
        end
        else if (hit)
        begin
            case (cfg_index)
                upsc_pkg::REG_SRC_WIDTH:
                    src_width_reg <= cfg_wdata;
                upsc_pkg::REG_SRC_HEIGHT:
                    src_height_reg <= cfg_wdata[upsc_pkg::SRC_H_BITS-1:0];
                upsc_pkg::REG_ASPECT_KEEP:
                    aspect_reg <= cfg_wdata[0];
                default:
                    aspect_reg <= aspect_reg;
            endcase
            state_reg <= GEO_FACTOR;
        end
        else
        begin
            case (state_reg)
                GEO_FACTOR:
                begin
                    scale_reg <= scale_next;
                    state_reg <= GEO_OFFSET;
                end
                GEO_OFFSET:
                begin
                    offset_x_reg <= offset_x_next;
                    offset_y_reg <= offset_y_next;
                    state_reg    <= GEO_IDLE;
                end
                default:
                    state_reg <= GEO_IDLE;
            endcase
        end
    end

    assign restart  = hit;
    assign busy     = (state_reg != GEO_IDLE);
    assign scale    = scale_reg;
    assign offset_x = offset_x_reg;
    assign offset_y = offset_y_reg;

endmodule

// ===== rtl/upsc_front.sv =====
// input side: raster position tracking and block origin per source pixel
`timescale 1ns / 1ps

module upsc_front #(
    parameter int COL_W  = 11,
    parameter int ROW_W  = 10,
    parameter int DATA_W = 37
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [upsc_pkg::PIX_BITS-1:0]      pixel_in,
    input  logic                               restart,
    input  logic                               geo_busy,
    input  upsc_pkg::scale_t                   scale,
    input  logic [COL_W-1:0]                   offset_x,
    input  logic [ROW_W-1:0]                   offset_y,
    input  logic [upsc_pkg::SRC_W_BITS-1:0]    eff_w,
    input  logic [upsc_pkg::SRC_H_BITS-1:0]    eff_h,
    input  logic                               q_full,
    output logic                               q_push,
    output logic [DATA_W-1:0]                  q_data
);

    localparam int XP_W = upsc_pkg::SRC_W_BITS + upsc_pkg::SCALE_BITS;
    localparam int YP_W = upsc_pkg::SRC_H_BITS + upsc_pkg::SCALE_BITS;

    logic [upsc_pkg::SRC_W_BITS-1:0] col_reg;
    logic [upsc_pkg::SRC_W_BITS-1:0] col_next;
    logic [upsc_pkg::SRC_H_BITS-1:0] row_reg;
    logic [upsc_pkg::SRC_H_BITS-1:0] row_next;
    logic [COL_W-1:0]                col0;
    logic [ROW_W-1:0]                row0;

    assign in_ready = !geo_busy && !q_full;
    assign q_push   = in_valid && in_ready;

    // top-left corner of this pixel's block
    assign col0 = COL_W'(XP_W'(offset_x) + XP_W'(col_reg) * XP_W'(scale.sx));
    assign row0 = ROW_W'(YP_W'(offset_y) + YP_W'(row_reg) * YP_W'(scale.sy));

    assign q_data = {pixel_in, col0, row0};

    // raster wrap
    always_comb
    begin
        col_next = col_reg + 1'b1;
        row_next = row_reg;
        if ({1'b0, col_reg} + 1'b1 >= {1'b0, eff_w})
        begin
            col_next = '0;
            if ({1'b0, row_reg} + 1'b1 >= {1'b0, eff_h})
                row_next = '0;
            else
                row_next = row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (q_push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/upsc_fifo.sv =====
// two-entry queue between the input side and the write generator
`timescale 1ns / 1ps

module upsc_fifo #(
    parameter int WIDTH = 37
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/upsc_back.sv =====
// write generator: walks one block row by row, one framebuffer write per cycle while out_ready is high
`timescale 1ns / 1ps

module upsc_back #(
    parameter int FRAME_WIDTH = 1280,
    parameter int COL_W       = 11,
    parameter int ROW_W       = 10,
    parameter int DATA_W      = 37
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [DATA_W-1:0]               q_data,
    output logic                            q_pop,
    input  upsc_pkg::scale_t                scale,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [upsc_pkg::ADDR_BITS-1:0]  dst_addr,
    output logic [upsc_pkg::PIX_BITS-1:0]   pixel_out,
    output logic                            block_last
);

    localparam int ADDR_W = COL_W + ROW_W;

    logic                              active_reg;
    logic [upsc_pkg::SCALE_BITS-1:0]   dx_reg;
    logic [upsc_pkg::SCALE_BITS-1:0]   dy_reg;
    logic [ADDR_W-1:0]                 addr_reg;
    logic [ADDR_W-1:0]                 row_addr_reg;
    logic [upsc_pkg::PIX_BITS-1:0]     pix_reg;

    logic [upsc_pkg::PIX_BITS-1:0]     head_pix;
    logic [COL_W-1:0]                  head_col;
    logic [ROW_W-1:0]                  head_row;
    logic [ADDR_W-1:0]                 head_addr;
    logic                              row_end;
    logic                              last;
    logic                              advance;

    assign {head_pix, head_col, head_row} = q_data;
    assign head_addr = ADDR_W'(head_row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(head_col);

    assign row_end = (dx_reg == scale.sx - 1'b1);
    assign last    = row_end && (dy_reg == scale.sy - 1'b1);
    assign advance = active_reg && out_ready;
    assign q_pop   = q_valid && (!active_reg || (advance && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (q_pop)
            active_reg <= 1'b1;
        else if (advance && last)
            active_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dx_reg       <= '0;
            dy_reg       <= '0;
            addr_reg     <= head_addr;
            row_addr_reg <= head_addr;
            pix_reg      <= head_pix;
        end
        else if (advance && !last)
        begin
            if (row_end)
            begin
                dx_reg       <= '0;
                dy_reg       <= dy_reg + 1'b1;
                addr_reg     <= row_addr_reg + ADDR_W'(FRAME_WIDTH);
                row_addr_reg <= row_addr_reg + ADDR_W'(FRAME_WIDTH);
            end
            else
            begin
                dx_reg   <= dx_reg + 1'b1;
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    generate
        if (ADDR_W >= upsc_pkg::ADDR_BITS)
        begin : g_addr_trunc
            assign dst_addr = addr_reg[upsc_pkg::ADDR_BITS-1:0];
        end
        else
        begin : g_addr_ext
            assign dst_addr = {{(upsc_pkg::ADDR_BITS-ADDR_W){1'b0}}, addr_reg};
        end
    endgenerate

    assign out_valid  = active_reg;
    assign pixel_out  = pix_reg;
    assign block_last = last;

endmodule

// ===== rtl/integer_nearest_upscaler_top.sv =====
// top level of the integer nearest-neighbor upscaler
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// -------   ---------  ---------------------  --------------------------------
// input     in         in_valid / in_ready    pixel_in
// output    out        out_valid / out_ready  dst_addr, pixel_out, block_last
// config    in         cfg_we (no wait)       cfg_index, cfg_wdata
//
// each source pixel becomes scale_x * scale_y framebuffer writes, issued by the write generator
// at one write per cycle while out_ready is high (four writes at 2x2, one at 1x1)
// the input side runs ahead through a two-entry queue, so it keeps taking
// pixels while the output is stalled until the queue fills
// a configuration write holds in_ready low while the factors
// and then the centering offsets are derived
// after reset the scale is 1 and the offsets are 0 until the first write

module integer_nearest_upscaler_top #(
    parameter int FRAME_WIDTH  = 1280,
    parameter int FRAME_HEIGHT = 720,
    parameter int MAX_SCALE    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [upsc_pkg::PIX_BITS-1:0]       pixel_in,
    // framebuffer writes
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [upsc_pkg::ADDR_BITS-1:0]      dst_addr,
    output logic [upsc_pkg::PIX_BITS-1:0]       pixel_out,
    output logic                                block_last,
    // configuration
    input  logic                                cfg_we,
    input  logic [upsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [upsc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    // column and row widths of the frame
    localparam int COL_W  = $clog2(FRAME_WIDTH);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);
    // queue entry: pixel, block column, block row
    localparam int DATA_W = upsc_pkg::PIX_BITS + COL_W + ROW_W;

    logic                               restart;
    logic                               geo_busy;
    upsc_pkg::scale_t                   scale;
    logic [COL_W-1:0]                   offset_x;
    logic [ROW_W-1:0]                   offset_y;
    logic [upsc_pkg::SRC_W_BITS-1:0]    eff_w;
    logic [upsc_pkg::SRC_H_BITS-1:0]    eff_h;

    logic                               q_push;
    logic [DATA_W-1:0]                  q_push_data;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_valid;
    logic [DATA_W-1:0]                  q_head;

    // registers, clamped dimensions and derived geometry
    upsc_geom #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .MAX_SCALE    (MAX_SCALE),
        .COL_W        (COL_W),
        .ROW_W        (ROW_W)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .restart   (restart),
        .busy      (geo_busy),
        .scale     (scale),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .eff_w     (eff_w),
        .eff_h     (eff_h)
    );

    // takes each input transaction and computes its block origin
    upsc_front #(
        .COL_W  (COL_W),
        .ROW_W  (ROW_W),
        .DATA_W (DATA_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel_in (pixel_in),
        .restart  (restart),
        .geo_busy (geo_busy),
        .scale    (scale),
        .offset_x (offset_x),
        .offset_y (offset_y),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // decouples the two sides
    upsc_fifo #(
        .WIDTH (DATA_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // expands each block into output transactions
    upsc_back #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .COL_W       (COL_W),
        .ROW_W       (ROW_W),
        .DATA_W      (DATA_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_head),
        .q_pop      (q_pop),
        .scale      (scale),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dst_addr   (dst_addr),
        .pixel_out  (pixel_out),
        .block_last (block_last)
    );

endmodule
